@@ design/scr_pkg.sv @@
`default_nettype none
package scr_pkg;

  localparam int ENTRIES_DEF    = 256;
  localparam int VALUE_BITS_DEF = 32;

  localparam int FUNC_BITS = 2;
  localparam int IDX_BITS  = 16;
  localparam int DATA_BITS = 32;
  localparam int POS_BITS  = 16;
  localparam int CNT_BITS  = 16;
  localparam int ERR_BITS  = 2;
  localparam int MODE_BITS = 3;
  localparam int ACT_BITS  = 9;
  localparam int RES_BITS  = DATA_BITS + POS_BITS + CNT_BITS + ERR_BITS;

  localparam logic [FUNC_BITS-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_SCATTER = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_READ    = 2'd2;

  localparam logic [MODE_BITS-1:0] MODE_MUL = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_DIV = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_SUM = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_MAX = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_MIN = 3'd4;

  localparam logic [ERR_BITS-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_DIVZ  = 2'd2;

  localparam logic CFG_MODE   = 1'b0;
  localparam logic CFG_ACTIVE = 1'b1;

  localparam logic [ACT_BITS-1:0] ACTIVE_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_SCATTER,
    OP_READ
  } op_t;

endpackage
`default_nettype wire

@@ design/scr_ram.sv @@
`default_nettype none
module scr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/scr_fifo.sv @@
`default_nettype none
module scr_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  output logic              full,
  input  wire logic [W-1:0] wdata,
  input  wire logic         pop,
  output logic              empty,
  output logic      [W-1:0] rdata
);

  logic [W-1:0] mem_r [2];
  logic         wr_ptr_r;
  logic         rd_ptr_r;
  logic [1:0]   cnt_r;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

@@ design/scr_front.sv @@
`default_nettype none
module scr_front import scr_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int AW         = $clog2(ENTRIES),
  parameter int QW         = 1 + 2 + AW + VALUE_BITS + POS_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [ACT_BITS-1:0]   cfg_data,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [FUNC_BITS-1:0]  in_func,
  input  wire logic [IDX_BITS-1:0]   in_entry_index,
  input  wire logic signed [DATA_BITS-1:0] in_data_value,
  input  wire logic [POS_BITS-1:0]   in_source_position,
  input  wire logic                  clear_busy,
  output logic [MODE_BITS-1:0]       mode_o,
  output logic                       q_push,
  input  wire logic                  q_full,
  output logic [QW-1:0]              q_data
);

  logic [MODE_BITS-1:0]         mode_r;
  logic [ACT_BITS-1:0]          active_r;
  op_t                          op;
  logic                         oor;
  logic signed [VALUE_BITS-1:0] d_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_MUL;
      active_r <= ACTIVE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODE) begin
        mode_r <= cfg_data[MODE_BITS-1:0];
      end else begin
        active_r <= cfg_data;
      end
    end
  end

  always_comb begin
    unique case (in_func)
      FUNC_LOAD:    op = OP_LOAD;
      FUNC_SCATTER: op = OP_SCATTER;
      default:      op = OP_READ;
    endcase
  end

  assign d_w = VALUE_BITS'(in_data_value);
  assign oor = ({1'b0, in_entry_index} >= 17'(active_r)) ||
               ({1'b0, in_entry_index} >= 17'(ENTRIES));

  assign mode_o  = mode_r;
  assign in_full = q_full || clear_busy;
  assign q_push  = in_push && !in_full;
  assign q_data  = {oor, op, in_entry_index[AW-1:0], d_w, in_source_position};

endmodule
`default_nettype wire

@@ design/scr_back.sv @@
`default_nettype none
module scr_back import scr_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int AW         = $clog2(ENTRIES),
  parameter int QW         = 1 + 2 + AW + VALUE_BITS + POS_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [MODE_BITS-1:0] mode,
  output logic                      clear_busy,
  input  wire logic                 q_empty,
  output logic                      q_pop,
  input  wire logic [QW-1:0]        q_data,
  input  wire logic                 res_full,
  output logic                      res_push,
  output logic [RES_BITS-1:0]       res_data
);

  localparam int VW = VALUE_BITS;
  localparam int CW = $clog2(VW);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_ITER,
    S_FIN,
    S_DONE
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       clr_r;
  op_t                 op_r;
  logic [AW-1:0]       addr_r;
  logic signed [VW-1:0] d_r;
  logic [POS_BITS-1:0] spos_r;
  logic signed [VW-1:0] val_r;
  logic [POS_BITS-1:0] pos_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic [ERR_BITS-1:0] err_r;
  logic                we_r;
  logic [VW-1:0]       acc_r;
  logic [VW-1:0]       opa_r;
  logic [VW-1:0]       opb_r;
  logic [VW:0]         rem_r;
  logic                neg_r;
  logic                div_r;
  logic [CW-1:0]       itc_r;

  logic                 q_oor;
  op_t                  q_op;
  logic [AW-1:0]        q_addr;
  logic signed [VW-1:0] q_d;
  logic [POS_BITS-1:0]  q_spos;
  logic signed [VW-1:0] rd_val;
  logic [POS_BITS-1:0]  rd_pos;
  logic [CNT_BITS-1:0]  rd_cnt;
  logic [VW-1:0]        mag_a;
  logic [VW-1:0]        mag_b;
  logic [VW:0]          rem_sh;
  logic                 q_bit;
  logic [VW:0]          rem_step;
  logic                 val_we;
  logic                 meta_we;
  logic [AW-1:0]        wr_addr;

  assign q_spos = q_data[POS_BITS-1:0];
  assign q_d    = q_data[POS_BITS +: VW];
  assign q_addr = q_data[POS_BITS+VW +: AW];
  assign q_op   = op_t'(q_data[POS_BITS+VW+AW +: 2]);
  assign q_oor  = q_data[QW-1];

  assign clear_busy = (state_r == S_CLEAR);
  assign q_pop      = (state_r == S_IDLE) && !q_empty;
  assign res_push   = (state_r == S_DONE) && !res_full;
  assign val_we     = res_push && we_r;
  assign meta_we    = clear_busy || val_we;
  assign wr_addr    = clear_busy ? clr_r : addr_r;

  scr_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(wr_addr), .wdata(val_r),
    .re(q_pop), .raddr(q_addr), .rdata(rd_val)
  );

  scr_ram #(.WIDTH(POS_BITS), .DEPTH(ENTRIES)) u_pos_ram (
    .clk(clk), .we(meta_we), .waddr(wr_addr),
    .wdata(clear_busy ? '0 : pos_r),
    .re(q_pop), .raddr(q_addr), .rdata(rd_pos)
  );

  scr_ram #(.WIDTH(CNT_BITS), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk(clk), .we(meta_we), .waddr(wr_addr),
    .wdata(clear_busy ? '0 : cnt_r),
    .re(q_pop), .raddr(q_addr), .rdata(rd_cnt)
  );

  assign mag_a    = rd_val[VW-1] ? -rd_val : rd_val;
  assign mag_b    = d_r[VW-1] ? -d_r : d_r;
  assign rem_sh   = {rem_r[VW-1:0], opa_r[VW-1]};
  assign q_bit    = rem_sh >= {1'b0, opb_r};
  assign rem_step = q_bit ? rem_sh - {1'b0, opb_r} : rem_sh;

  assign res_data = {DATA_BITS'(val_r), pos_r, cnt_r, err_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(ENTRIES - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            op_r   <= q_op;
            addr_r <= q_addr;
            d_r    <= q_d;
            spos_r <= q_spos;
            if (q_oor) begin
              val_r   <= '0;
              pos_r   <= '0;
              cnt_r   <= '0;
              err_r   <= ERR_RANGE;
              we_r    <= 1'b0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          val_r   <= rd_val;
          pos_r   <= rd_pos;
          cnt_r   <= rd_cnt;
          err_r   <= ERR_OK;
          we_r    <= 1'b0;
          state_r <= S_DONE;
          unique case (op_r)
            OP_LOAD: begin
              val_r <= d_r;
              pos_r <= '0;
              cnt_r <= '0;
              we_r  <= 1'b1;
            end
            OP_SCATTER: begin
              case (mode)
                MODE_MUL: begin
                  acc_r   <= '0;
                  opa_r   <= rd_val;
                  opb_r   <= d_r;
                  div_r   <= 1'b0;
                  itc_r   <= '0;
                  state_r <= S_ITER;
                end
                MODE_DIV: begin
                  if (d_r == '0) begin
                    err_r <= ERR_DIVZ;
                  end else begin
                    opa_r   <= mag_a;
                    opb_r   <= mag_b;
                    rem_r   <= '0;
                    neg_r   <= rd_val[VW-1] ^ d_r[VW-1];
                    div_r   <= 1'b1;
                    itc_r   <= '0;
                    state_r <= S_ITER;
                  end
                end
                MODE_SUM: begin
                  val_r <= rd_val + d_r;
                  if (rd_cnt != '1) begin
                    cnt_r <= rd_cnt + CNT_BITS'(1);
                  end
                  we_r <= 1'b1;
                end
                MODE_MAX: begin
                  if (!(d_r < rd_val)) begin
                    val_r <= d_r;
                    pos_r <= spos_r;
                    we_r  <= 1'b1;
                  end
                end
                MODE_MIN: begin
                  if (!(rd_val < d_r)) begin
                    val_r <= d_r;
                    pos_r <= spos_r;
                    we_r  <= 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
            default: begin
            end
          endcase
        end
        S_ITER: begin
          if (div_r) begin
            rem_r <= rem_step;
            opa_r <= {opa_r[VW-2:0], q_bit};
          end else begin
            acc_r <= acc_r + (opb_r[0] ? opa_r : '0);
            opa_r <= opa_r << 1;
            opb_r <= opb_r >> 1;
          end
          itc_r <= itc_r + CW'(1);
          if (itc_r == CW'(VW - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          val_r   <= div_r ? (neg_r ? -opa_r : opa_r) : acc_r;
          we_r    <= 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!res_full) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_CLEAR |=> state_r != S_CLEAR)
    else $error("clearing pass entered again");

  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && err_r != ERR_OK |-> !val_we && !meta_we)
    else $error("table written on an error result");

  a_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> state_r == S_IDLE)
    else $error("back end not idle after result transfer");

endmodule
`default_nettype wire

@@ design/scatter_reduce_table_core.sv @@
`default_nettype none
// scatter-reduce table: load entries, scatter values into them by the
// configured reduction, read them back; one result per item, in order.
// in the back end, load, read, sum and max/min items go through queue pop
// and table read, update, and result transfer; out-of-range items skip the
// update. multiply and divide (but for a zero divisor) iterate in between,
// one bit per cycle, in the shift-add multiplier and restoring divider.
// after reset a clearing pass zeroes the position and count tables while
// full stays high. configuration is taken at any time but meant for idle
// periods.
module scatter_reduce_table_core import scr_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [ACT_BITS-1:0]         cfg_data,
  input  wire logic                        in_push,
  output logic                             in_full,
  input  wire logic [FUNC_BITS-1:0]        in_func,
  input  wire logic [IDX_BITS-1:0]         in_entry_index,
  input  wire logic signed [DATA_BITS-1:0] in_data_value,
  input  wire logic [POS_BITS-1:0]         in_source_position,
  output logic                             out_empty,
  input  wire logic                        out_pop,
  output logic signed [DATA_BITS-1:0]      out_entry_value,
  output logic [POS_BITS-1:0]              out_winning_position,
  output logic [CNT_BITS-1:0]              out_entry_count,
  output logic [ERR_BITS-1:0]              out_error_code
);

  localparam int AW = $clog2(ENTRIES);
  localparam int QW = 1 + 2 + AW + VALUE_BITS + POS_BITS;

  logic [MODE_BITS-1:0] mode;
  logic                 clear_busy;
  logic                 q_push;
  logic                 q_full;
  logic [QW-1:0]        q_wdata;
  logic                 q_pop;
  logic                 q_empty;
  logic [QW-1:0]        q_rdata;
  logic                 res_push;
  logic                 res_full;
  logic [RES_BITS-1:0]  res_wdata;
  logic [RES_BITS-1:0]  res_rdata;

  scr_front #(.ENTRIES(ENTRIES), .VALUE_BITS(VALUE_BITS), .AW(AW), .QW(QW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_func(in_func),
    .in_entry_index(in_entry_index), .in_data_value(in_data_value),
    .in_source_position(in_source_position),
    .clear_busy(clear_busy), .mode_o(mode),
    .q_push(q_push), .q_full(q_full), .q_data(q_wdata)
  );

  scr_fifo #(.W(QW)) u_item_q (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .full(q_full), .wdata(q_wdata),
    .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
  );

  scr_back #(.ENTRIES(ENTRIES), .VALUE_BITS(VALUE_BITS), .AW(AW), .QW(QW)) u_back (
    .clk(clk), .rst_n(rst_n), .mode(mode), .clear_busy(clear_busy),
    .q_empty(q_empty), .q_pop(q_pop), .q_data(q_rdata),
    .res_full(res_full), .res_push(res_push), .res_data(res_wdata)
  );

  scr_fifo #(.W(RES_BITS)) u_res_q (
    .clk(clk), .rst_n(rst_n),
    .push(res_push), .full(res_full), .wdata(res_wdata),
    .pop(out_pop), .empty(out_empty), .rdata(res_rdata)
  );

  assign out_entry_value      = res_rdata[RES_BITS-1 -: DATA_BITS];
  assign out_winning_position = res_rdata[CNT_BITS+ERR_BITS +: POS_BITS];
  assign out_entry_count      = res_rdata[ERR_BITS +: CNT_BITS];
  assign out_error_code       = res_rdata[ERR_BITS-1:0];

endmodule
`default_nettype wire

@@ test/scatter_reduce_table_core_tb.sv @@
`default_nettype none
module scatter_reduce_table_core_tb;
  import scr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = ENTRIES_DEF;

  typedef struct packed {
    logic [FUNC_BITS-1:0]        func;
    logic [IDX_BITS-1:0]         idx;
    logic signed [DATA_BITS-1:0] data;
    logic [POS_BITS-1:0]         spos;
  } item_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] value;
    logic [POS_BITS-1:0]         pos;
    logic [CNT_BITS-1:0]         cnt;
    logic [ERR_BITS-1:0]         err;
  } entry_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [ACT_BITS-1:0] cfg_data;
  logic in_push;
  logic in_full;
  logic [FUNC_BITS-1:0] in_func;
  logic [IDX_BITS-1:0] in_entry_index;
  logic signed [DATA_BITS-1:0] in_data_value;
  logic [POS_BITS-1:0] in_source_position;
  logic out_empty;
  logic out_pop;
  logic signed [DATA_BITS-1:0] out_entry_value;
  logic [POS_BITS-1:0] out_winning_position;
  logic [CNT_BITS-1:0] out_entry_count;
  logic [ERR_BITS-1:0] out_error_code;

  scatter_reduce_table_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_func(in_func),
    .in_entry_index(in_entry_index), .in_data_value(in_data_value),
    .in_source_position(in_source_position),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_entry_value(out_entry_value), .out_winning_position(out_winning_position),
    .out_entry_count(out_entry_count), .out_error_code(out_error_code)
  );

  logic signed [DATA_BITS-1:0] tbl_value [ENTRIES];
  logic [POS_BITS-1:0]         tbl_pos [ENTRIES];
  logic [CNT_BITS-1:0]         tbl_cnt [ENTRIES];
  bit                          tbl_loaded [ENTRIES];
  logic [MODE_BITS-1:0]        mode_q;
  logic [ACT_BITS-1:0]         active_q;

  item_t      pending_items[$];
  entry_res_t expected_entries[$];
  int         errors;
  bit         feeding;
  int         send_gap;
  int         pop_gap;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(21, 80);
  endfunction

  function automatic entry_res_t reduce_entry(item_t it);
    entry_res_t r;
    int unsigned lim;
    logic signed [DATA_BITS-1:0] cur;
    logic [DATA_BITS-1:0] mc;
    logic [DATA_BITS-1:0] md;
    logic [DATA_BITS-1:0] q;
    int unsigned i;
    r = '0;
    lim = (active_q < ENTRIES) ? active_q : ENTRIES;
    if (it.idx >= lim) begin
      r.err = ERR_RANGE;
      return r;
    end
    i = it.idx;
    r.err = ERR_OK;
    if (it.func == FUNC_LOAD) begin
      tbl_value[i] = it.data;
      tbl_pos[i] = '0;
      tbl_cnt[i] = '0;
      tbl_loaded[i] = 1'b1;
    end else if (it.func == FUNC_SCATTER) begin
      cur = tbl_value[i];
      case (mode_q)
        MODE_MUL: tbl_value[i] = cur * it.data;
        MODE_DIV: begin
          if (it.data == 0) begin
            r.err = ERR_DIVZ;
          end else begin
            mc = cur[DATA_BITS-1] ? -cur : cur;
            md = it.data[DATA_BITS-1] ? -it.data : it.data;
            q = mc / md;
            if (cur[DATA_BITS-1] ^ it.data[DATA_BITS-1]) q = -q;
            tbl_value[i] = q;
          end
        end
        MODE_SUM: begin
          tbl_value[i] = cur + it.data;
          if (tbl_cnt[i] != '1) tbl_cnt[i] = tbl_cnt[i] + 1'b1;
        end
        MODE_MAX: begin
          if (!(it.data < cur)) begin
            tbl_value[i] = it.data;
            tbl_pos[i] = it.spos;
          end
        end
        MODE_MIN: begin
          if (!(cur < it.data)) begin
            tbl_value[i] = it.data;
            tbl_pos[i] = it.spos;
          end
        end
        default: ;
      endcase
    end
    r.value = tbl_value[i];
    r.pos = tbl_pos[i];
    r.cnt = tbl_cnt[i];
    return r;
  endfunction

  // items on unloaded in-range entries would read undefined values
  function automatic bit touches_unloaded(item_t it);
    int unsigned lim;
    lim = (active_q < ENTRIES) ? active_q : ENTRIES;
    if (it.func == FUNC_LOAD || it.idx >= lim) return 1'b0;
    return !tbl_loaded[it.idx];
  endfunction

  function automatic logic signed [DATA_BITS-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return -1;
      4: return DATA_BITS'($urandom_range(0, 20) - 10);
      5: return DATA_BITS'($urandom_range(1, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_BITS-1:0] rand_index();
    int unsigned lim;
    lim = (active_q < ENTRIES) ? active_q : ENTRIES;
    case ($urandom_range(0, 19))
      0: return IDX_BITS'($urandom);
      1: return IDX_BITS'(lim);
      2: return 16'hffff;
      default: return IDX_BITS'($urandom_range(0, lim - 1));
    endcase
  endfunction

  task automatic add_item(logic [FUNC_BITS-1:0] f, logic [IDX_BITS-1:0] idx,
                          logic signed [DATA_BITS-1:0] d, logic [POS_BITS-1:0] p);
    item_t it;
    it.func = f;
    it.idx = idx;
    it.data = d;
    it.spos = p;
    if (touches_unloaded(it)) it.func = FUNC_LOAD;
    pending_items.push_back(it);
    expected_entries.push_back(reduce_entry(it));
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_entries.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [ACT_BITS-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MODE) mode_q = d[MODE_BITS-1:0];
    else active_q = d;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("[scatter_reduce_table_core] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
      send_gap <= 0;
    end else if (!(in_push && in_full)) begin
      if (in_push) void'(pending_items.pop_front());
      if (send_gap > 0 || !feeding) begin
        in_push <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else if (pending_items.size() != 0) begin
        item_t it;
        it = pending_items[0];
        in_push <= 1'b1;
        in_func <= it.func;
        in_entry_index <= it.idx;
        in_data_value <= it.data;
        in_source_position <= it.spos;
        send_gap <= rand_gap();
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_entries.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          entry_res_t e;
          e = expected_entries.pop_front();
          if (out_entry_value !== e.value) begin
            $error("entry_value exp %0d got %0d", e.value, out_entry_value);
            errors++;
          end
          if (out_winning_position !== e.pos) begin
            $error("winning_position exp %0d got %0d", e.pos, out_winning_position);
            errors++;
          end
          if (out_entry_count !== e.cnt) begin
            $error("entry_count exp %0d got %0d", e.cnt, out_entry_count);
            errors++;
          end
          if (out_error_code !== e.err) begin
            $error("error_code exp %0d got %0d", e.err, out_error_code);
            errors++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (out_pop && !out_empty) pop_gap <= rand_gap();
      end
    end
  end

  initial begin
    logic [MODE_BITS-1:0] m;
    int n;
    errors = 0;
    feeding = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODE;
    cfg_data = '0;
    in_push = 1'b0;
    in_func = FUNC_LOAD;
    in_entry_index = '0;
    in_data_value = '0;
    in_source_position = '0;
    out_pop = 1'b0;
    mode_q = MODE_MUL;
    active_q = ACTIVE_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_value[i] = '0;
      tbl_pos[i] = '0;
      tbl_cnt[i] = '0;
      tbl_loaded[i] = 1'b0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    feeding = 1'b1;

    // directed: range edges, each mode, divide by zero, overflow, ties
    add_item(FUNC_LOAD, 0, 32'sh80000000, 16'hffff);
    add_item(FUNC_LOAD, 255, 32'sh7fffffff, 0);
    add_item(FUNC_LOAD, 256, 5, 1);
    add_item(FUNC_READ, 16'hffff, -1, 16'hffff);
    add_item(FUNC_SCATTER, 255, 2, 3);
    add_item(2'd3, 255, 0, 0);
    drain();
    write_cfg(CFG_MODE, MODE_DIV);
    add_item(FUNC_SCATTER, 0, 0, 0);
    add_item(FUNC_SCATTER, 0, -1, 0);
    add_item(FUNC_SCATTER, 255, -7, 0);
    drain();
    write_cfg(CFG_MODE, MODE_SUM);
    add_item(FUNC_SCATTER, 0, -1, 0);
    add_item(FUNC_SCATTER, 0, 32'sh7fffffff, 0);
    drain();
    write_cfg(CFG_MODE, MODE_MAX);
    add_item(FUNC_LOAD, 1, 10, 0);
    add_item(FUNC_SCATTER, 1, 10, 16'h1234);
    add_item(FUNC_SCATTER, 1, 9, 16'h0001);
    add_item(FUNC_SCATTER, 1, 32'sh7fffffff, 16'hffff);
    drain();
    write_cfg(CFG_MODE, MODE_MIN);
    add_item(FUNC_SCATTER, 1, 32'sh7fffffff, 16'h0042);
    add_item(FUNC_SCATTER, 1, 32'sh80000000, 16'h8000);
    drain();
    write_cfg(CFG_MODE, 3'd7);
    add_item(FUNC_SCATTER, 1, 3, 3);
    drain();
    write_cfg(CFG_ACTIVE, 1);
    add_item(FUNC_READ, 0, 0, 0);
    add_item(FUNC_READ, 1, 0, 0);
    drain();

    // repeated sums on one entry
    write_cfg(CFG_ACTIVE, ACTIVE_RESET);
    write_cfg(CFG_MODE, MODE_SUM);
    add_item(FUNC_LOAD, 2, 0, 0);
    for (int k = 0; k < 16; k++) begin
      add_item(FUNC_SCATTER, 2, 1, 0);
      if (pending_items.size() > 64) @(posedge clk);
    end
    drain();

    for (int ph = 0; ph < 11; ph++) begin
      m = (ph < 10) ? MODE_BITS'(ph % 5) : MODE_BITS'($urandom_range(5, 7));
      write_cfg(CFG_MODE, m);
      case (ph % 4)
        0: write_cfg(CFG_ACTIVE, ACTIVE_RESET);
        1: write_cfg(CFG_ACTIVE, ACT_BITS'($urandom_range(1, 8)));
        2: write_cfg(CFG_ACTIVE, 0);
        default: write_cfg(CFG_ACTIVE, ACT_BITS'($urandom_range(1, 511)));
      endcase
      n = 100;
      for (int k = 0; k < n; k++) begin
        int r;
        r = $urandom_range(0, 9);
        add_item(r < 2 ? FUNC_LOAD : (r < 8 ? FUNC_SCATTER : (r == 8 ? FUNC_READ : 2'd3)),
                 rand_index(), rand_value(), POS_BITS'($urandom));
      end
      drain();
    end

    feeding = 1'b0;
    if (errors == 0) begin
      $display("[scatter_reduce_table_core] OK");
    end else begin
      $display("[scatter_reduce_table_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ scatter_reduce_table_core.f @@
design/scr_pkg.sv
design/scr_ram.sv
design/scr_fifo.sv
design/scr_front.sv
design/scr_back.sv
design/scatter_reduce_table_core.sv
test/scatter_reduce_table_core_tb.sv
